/* rtl/core/text_console_cursor_scroll_top_macros.svh */
// assertion macros for the text console cursor and scroll block
`ifndef TEXT_CONSOLE_CURSOR_SCROLL_TOP_MACROS_SVH
`define TEXT_CONSOLE_CURSOR_SCROLL_TOP_MACROS_SVH

`ifndef SYNTHESIS

`define TCC_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error(msg);

`define TCC_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

`define TCC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define TCC_ASSERT_ALWAYS(label, clk, rst, cond, msg)
`define TCC_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg)
`define TCC_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

/* rtl/core/tcc_pkg.sv */
// shared types and constants for the text console cursor and scroll block
package tcc_pkg;

   localparam int ACTION_W = 2;
   localparam int CHAR_W   = 8;
   localparam int INDEX_W  = 11;
   localparam int POS_W    = 11;
   localparam int ROW_W    = 5;
   localparam int COL_W    = 7;

   localparam logic [ACTION_W-1:0] ACT_PUT   = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_READ  = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd2;

   localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
   localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
   localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;

   typedef enum logic [2:0] {
      OP_IDLE,
      OP_LOAD,
      OP_EXEC,
      OP_COPY,
      OP_FILL,
      OP_CLEAR
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
   } tcc_cmd_type;

   typedef struct packed {
      logic need_scroll;
      logic need_clear;
      logic copy_end;
      logic fill_end;
      logic clear_end;
   } tcc_status_type;

endpackage

/* rtl/core/tcc_ctrl.sv */
// controller state machine for the text console cursor and scroll block
module tcc_ctrl import tcc_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  tcc_status_type status,
   output tcc_cmd_type    cmd,
   output logic           busy,
   output logic           rsp_valid
);

   typedef enum logic [2:0] {
      S_INIT,
      S_IDLE,
      S_EXEC,
      S_COPY,
      S_FILL,
      S_WIPE
   } state_type;

   state_type state_ff, state_in;
   logic      busy_ff;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = 1'b0;
      cmd.op       = OP_IDLE;
      unique case (state_ff)
         S_INIT: begin
            cmd.op = OP_CLEAR;
            if (status.clear_end) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               cmd.op   = OP_LOAD;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            cmd.op = OP_EXEC;
            if (status.need_scroll) begin
               state_in = S_COPY;
            end else if (status.need_clear) begin
               state_in = S_WIPE;
            end else begin
               state_in     = S_IDLE;
               rsp_valid_in = 1'b1;
            end
         end
         S_COPY: begin
            cmd.op = OP_COPY;
            if (status.copy_end) begin
               state_in = S_FILL;
            end
         end
         S_FILL: begin
            cmd.op = OP_FILL;
            if (status.fill_end) begin
               state_in     = S_IDLE;
               rsp_valid_in = 1'b1;
            end
         end
         S_WIPE: begin
            cmd.op = OP_CLEAR;
            if (status.clear_end) begin
               state_in     = S_IDLE;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         busy_ff      <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         busy_ff      <= (state_in != S_IDLE);
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign busy      = busy_ff;
   assign rsp_valid = rsp_valid_ff;

endmodule

/* rtl/core/tcc_datapath.sv */
// screen store, cursor registers and sweep counter of the text console
module tcc_datapath import tcc_pkg::*; #(
   parameter int ROW_COUNT = 25,
   parameter int COL_COUNT = 80
) (
   input  logic                clock,
   input  logic                reset,
   input  tcc_cmd_type         cmd,
   output tcc_status_type      status,
   input  logic [ACTION_W-1:0] req_action,
   input  logic [CHAR_W-1:0]   req_char_code,
   input  logic [INDEX_W-1:0]  req_cell_index,
   output logic [POS_W-1:0]    rsp_cursor_pos,
   output logic [ROW_W-1:0]    rsp_cur_row,
   output logic [COL_W-1:0]    rsp_cur_col,
   output logic [CHAR_W-1:0]   rsp_read_data
);

   localparam int CELL_TOTAL     = ROW_COUNT * COL_COUNT;
   localparam int LAST_ROW_START = CELL_TOTAL - COL_COUNT;
   localparam int ADDR_W         = $clog2(CELL_TOTAL);
   localparam int CNT_W          = $clog2(CELL_TOTAL + 1);
   localparam int RW             = $clog2(ROW_COUNT);
   localparam int CW             = $clog2(COL_COUNT);

   logic [CHAR_W-1:0] screen_mem [CELL_TOTAL];

   logic [ACTION_W-1:0] act_ff;
   logic [CHAR_W-1:0]   char_ff;
   logic [INDEX_W-1:0]  idx_ff;
   logic [ADDR_W-1:0]   pos_ff, pos_in;
   logic [RW-1:0]       row_ff, row_in;
   logic [CW-1:0]       col_ff, col_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [CHAR_W-1:0]   rdata_ff;
   logic                rd_sel_ff, rd_sel_in;

   logic                wr_en;
   logic [ADDR_W-1:0]   wr_addr;
   logic [CHAR_W-1:0]   wr_data;
   logic                rd_en;
   logic [ADDR_W-1:0]   rd_addr;

   logic                is_put, is_newline, is_backspace;
   logic                at_last_row, at_last_col, at_last_cell;
   logic [31:0]         idx_wide;
   logic                idx_ok;
   logic [CNT_W-1:0]    cnt_plus_col, cnt_dec;
   logic [31:0]         pos_wide, row_wide, col_wide;

   assign is_put       = (act_ff == ACT_PUT);
   assign is_newline   = (char_ff == CH_NEWLINE);
   assign is_backspace = (char_ff == CH_BACKSPACE);
   assign at_last_row  = (row_ff == RW'(ROW_COUNT - 1));
   assign at_last_col  = (col_ff == CW'(COL_COUNT - 1));
   assign at_last_cell = (pos_ff == ADDR_W'(CELL_TOTAL - 1));
   assign idx_wide     = 32'(idx_ff);
   assign idx_ok       = (idx_wide < 32'(CELL_TOTAL));
   assign cnt_plus_col = cnt_ff + CNT_W'(COL_COUNT);
   assign cnt_dec      = cnt_ff - CNT_W'(1);

   assign status.need_scroll = is_put &&
                               ((is_newline && at_last_row) ||
                                (!is_newline && !is_backspace && at_last_cell));
   assign status.need_clear  = (act_ff == ACT_CLEAR);
   assign status.copy_end    = (cnt_ff == CNT_W'(LAST_ROW_START));
   assign status.fill_end    = (cnt_ff == CNT_W'(CELL_TOTAL));
   assign status.clear_end   = (cnt_ff == CNT_W'(CELL_TOTAL - 1));

   always_comb begin
      pos_in    = pos_ff;
      row_in    = row_ff;
      col_in    = col_ff;
      cnt_in    = cnt_ff;
      rd_sel_in = rd_sel_ff;
      wr_en     = 1'b0;
      wr_addr   = pos_ff;
      wr_data   = CH_SPACE;
      rd_en     = 1'b0;
      rd_addr   = idx_wide[ADDR_W-1:0];
      unique case (cmd.op) inside
         OP_IDLE, OP_LOAD: begin
         end
         OP_EXEC: begin
            cnt_in    = '0;
            rd_sel_in = (act_ff == ACT_READ) && idx_ok;
            rd_en     = rd_sel_in;
            case (act_ff)
               ACT_PUT: begin
                  if (is_newline) begin
                     col_in = '0;
                     if (at_last_row) begin
                        pos_in = ADDR_W'(LAST_ROW_START);
                     end else begin
                        pos_in = pos_ff - ADDR_W'(col_ff) + ADDR_W'(COL_COUNT);
                        row_in = row_ff + RW'(1);
                     end
                  end else if (is_backspace) begin
                     wr_en = 1'b1;
                     if (pos_ff != '0) begin
                        pos_in  = pos_ff - ADDR_W'(1);
                        wr_addr = pos_in;
                        if (col_ff == '0) begin
                           col_in = CW'(COL_COUNT - 1);
                           row_in = row_ff - RW'(1);
                        end else begin
                           col_in = col_ff - CW'(1);
                        end
                     end
                  end else begin
                     wr_en   = 1'b1;
                     wr_data = char_ff;
                     if (at_last_cell) begin
                        pos_in = ADDR_W'(LAST_ROW_START);
                        col_in = '0;
                     end else begin
                        pos_in = pos_ff + ADDR_W'(1);
                        if (at_last_col) begin
                           col_in = '0;
                           row_in = row_ff + RW'(1);
                        end else begin
                           col_in = col_ff + CW'(1);
                        end
                     end
                  end
               end
               ACT_CLEAR: begin
                  pos_in = '0;
                  row_in = '0;
                  col_in = '0;
               end
               default: begin
               end
            endcase
         end
         OP_COPY: begin
            cnt_in    = cnt_ff + CNT_W'(1);
            rd_sel_in = 1'b0;
            rd_en     = !status.copy_end;
            rd_addr   = cnt_plus_col[ADDR_W-1:0];
            wr_en     = (cnt_ff != '0);
            wr_addr   = cnt_dec[ADDR_W-1:0];
            wr_data   = rdata_ff;
         end
         OP_FILL: begin
            cnt_in  = cnt_ff + CNT_W'(1);
            wr_en   = 1'b1;
            wr_addr = cnt_dec[ADDR_W-1:0];
         end
         OP_CLEAR: begin
            cnt_in    = cnt_ff + CNT_W'(1);
            rd_sel_in = 1'b0;
            wr_en     = 1'b1;
            wr_addr   = cnt_ff[ADDR_W-1:0];
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         row_ff    <= '0;
         col_ff    <= '0;
         cnt_ff    <= '0;
         rd_sel_ff <= 1'b0;
      end else begin
         pos_ff    <= pos_in;
         row_ff    <= row_in;
         col_ff    <= col_in;
         cnt_ff    <= cnt_in;
         rd_sel_ff <= rd_sel_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == OP_LOAD) begin
         act_ff  <= req_action;
         char_ff <= req_char_code;
         idx_ff  <= req_cell_index;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         screen_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rdata_ff <= screen_mem[rd_addr];
      end
   end

   assign pos_wide = 32'(pos_ff);
   assign row_wide = 32'(row_ff);
   assign col_wide = 32'(col_ff);

   assign rsp_cursor_pos = pos_wide[POS_W-1:0];
   assign rsp_cur_row    = row_wide[ROW_W-1:0];
   assign rsp_cur_col    = col_wide[COL_W-1:0];
   assign rsp_read_data  = rd_sel_ff ? rdata_ff : '0;

endmodule

/* rtl/core/text_console_cursor_scroll_top.sv */
// top level of the text console with linear cursor and scrolling
//
//   channel   handshake              payload
//   request   start, busy            req_action, req_char_code, req_cell_index
//   response  rsp_valid (one cycle)  rsp_cursor_pos, rsp_cur_row,
//                                    rsp_cur_col, rsp_read_data
//
// put, read and unused actions pass through one execute state, then the
// response strobe, during which the next start is taken
// a put that scrolls walks the screen memory: a copy pass, then a fill of the last row
// clear writes a space to every cell, one memory write port sets the pace
// after reset a clearing pass over every cell runs with busy high
// the response is never held off; busy alone paces the requester
`include "text_console_cursor_scroll_top_macros.svh"

module text_console_cursor_scroll_top import tcc_pkg::*; #(
   parameter int ROW_COUNT = 25,
   parameter int COL_COUNT = 80
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [ACTION_W-1:0] req_action,
   input  logic [CHAR_W-1:0]   req_char_code,
   input  logic [INDEX_W-1:0]  req_cell_index,
   output logic                rsp_valid,
   output logic [POS_W-1:0]    rsp_cursor_pos,
   output logic [ROW_W-1:0]    rsp_cur_row,
   output logic [COL_W-1:0]    rsp_cur_col,
   output logic [CHAR_W-1:0]   rsp_read_data
);

   tcc_cmd_type    cmd;
   tcc_status_type status;

   tcc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .status    (status),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   tcc_datapath #(
      .ROW_COUNT (ROW_COUNT),
      .COL_COUNT (COL_COUNT)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_action     (req_action),
      .req_char_code  (req_char_code),
      .req_cell_index (req_cell_index),
      .rsp_cursor_pos (rsp_cursor_pos),
      .rsp_cur_row    (rsp_cur_row),
      .rsp_cur_col    (rsp_cur_col),
      .rsp_read_data  (rsp_read_data)
   );

   // response strobes never come back to back
   `TCC_ASSERT_NEXT(a_rsp_single, clock, reset, rsp_valid, !rsp_valid, "back to back response")
   // an accepted transfer makes the block busy
   `TCC_ASSERT_NEXT(a_start_busy, clock, reset, start && !busy, busy, "busy missing after start")
   // a response only while the block is free
   `TCC_ASSERT_IMPLIES(a_rsp_idle, clock, reset, rsp_valid, !busy, "response while busy")
   // cursor stays on the screen
   `TCC_ASSERT_ALWAYS(a_cursor_range, clock, reset,
      (rsp_cur_row < ROW_COUNT) && (rsp_cur_col < COL_COUNT), "cursor off screen")

endmodule

/* bench/text_console_cursor_scroll_top_tb.sv */
// self-checking testbench for the text console cursor and scroll block
`timescale 1ns / 100ps

module text_console_cursor_scroll_top_tb import tcc_pkg::*; ();

   localparam int ROWS       = 25;
   localparam int COLS       = 80;
   localparam int CELLS      = ROWS * COLS;
   localparam int RAND_ITEMS = 925;
   localparam int CALM_ITEMS = 150;
   localparam int DIR_ROWS   = 25;

   localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

   typedef struct packed {
      logic [POS_W-1:0]  pos;
      logic [ROW_W-1:0]  row;
      logic [COL_W-1:0]  col;
      logic [CHAR_W-1:0] data;
   } console_report_type;

   typedef struct packed {
      logic [ACTION_W-1:0] act;
      logic [CHAR_W-1:0]   ch;
      logic [INDEX_W-1:0]  idx;
      int                  reps;
      bit                  typed;
      console_report_type  want;
   } stim_row_type;

   logic                clock;
   logic                reset          = 1'b1;
   logic                start          = 1'b0;
   logic [ACTION_W-1:0] req_action     = ACT_READ;
   logic [CHAR_W-1:0]   req_char_code  = '0;
   logic [INDEX_W-1:0]  req_cell_index = '0;
   logic                busy;
   logic                rsp_valid;
   logic [POS_W-1:0]    rsp_cursor_pos;
   logic [ROW_W-1:0]    rsp_cur_row;
   logic [COL_W-1:0]    rsp_cur_col;
   logic [CHAR_W-1:0]   rsp_read_data;

   logic [CHAR_W-1:0]  shadow_screen [CELLS];
   int                 shadow_cursor;
   console_report_type cursor_report_q [$];
   int                 fail_count = 0;

   // directed rows: extremes, backspace at home, newline and wrap on the last row
   stim_row_type directed_stim [DIR_ROWS] = '{
      '{ACT_READ,   8'h00,        11'd0,    1,  1'b1, '{11'd0,    5'd0,  7'd0, 8'h20}},
      '{ACT_READ,   8'h00,        11'd1999, 1,  1'b1, '{11'd0,    5'd0,  7'd0, 8'h20}},
      '{ACT_READ,   8'h00,        11'd2000, 1,  1'b1, '{11'd0,    5'd0,  7'd0, 8'h00}},
      '{ACT_READ,   8'h00,        11'd2047, 1,  1'b1, '{11'd0,    5'd0,  7'd0, 8'h00}},
      '{ACT_PUT,    CH_BACKSPACE, 11'd0,    1,  1'b1, '{11'd0,    5'd0,  7'd0, 8'h00}},
      '{ACT_PUT,    8'h41,        11'd0,    1,  1'b1, '{11'd1,    5'd0,  7'd1, 8'h00}},
      '{ACT_PUT,    8'hFF,        11'd0,    1,  1'b1, '{11'd2,    5'd0,  7'd2, 8'h00}},
      '{ACT_PUT,    8'h00,        11'd0,    1,  1'b1, '{11'd3,    5'd0,  7'd3, 8'h00}},
      '{ACT_READ,   8'h00,        11'd0,    1,  1'b1, '{11'd3,    5'd0,  7'd3, 8'h41}},
      '{ACT_READ,   8'h00,        11'd1,    1,  1'b1, '{11'd3,    5'd0,  7'd3, 8'hFF}},
      '{ACT_PUT,    CH_BACKSPACE, 11'd0,    1,  1'b1, '{11'd2,    5'd0,  7'd2, 8'h00}},
      '{ACT_READ,   8'h00,        11'd2,    1,  1'b1, '{11'd2,    5'd0,  7'd2, 8'h20}},
      '{ACT_PUT,    CH_NEWLINE,   11'd0,    1,  1'b1, '{11'd80,   5'd1,  7'd0, 8'h00}},
      '{ACT_UNUSED, 8'hFF,        11'd2047, 1,  1'b1, '{11'd80,   5'd1,  7'd0, 8'h00}},
      '{ACT_CLEAR,  8'hAA,        11'd1365, 1,  1'b1, '{11'd0,    5'd0,  7'd0, 8'h00}},
      '{ACT_READ,   8'h00,        11'd1,    1,  1'b1, '{11'd0,    5'd0,  7'd0, 8'h20}},
      '{ACT_PUT,    CH_NEWLINE,   11'd0,    24, 1'b0, '{11'd0,    5'd0,  7'd0, 8'h00}},
      '{ACT_PUT,    8'h5A,        11'd0,    1,  1'b1, '{11'd1921, 5'd24, 7'd1, 8'h00}},
      '{ACT_PUT,    CH_NEWLINE,   11'd0,    1,  1'b1, '{11'd1920, 5'd24, 7'd0, 8'h00}},
      '{ACT_READ,   8'h00,        11'd1840, 1,  1'b1, '{11'd1920, 5'd24, 7'd0, 8'h5A}},
      '{ACT_READ,   8'h00,        11'd1920, 1,  1'b1, '{11'd1920, 5'd24, 7'd0, 8'h20}},
      '{ACT_PUT,    8'h7E,        11'd0,    79, 1'b0, '{11'd0,    5'd0,  7'd0, 8'h00}},
      '{ACT_PUT,    8'h7E,        11'd0,    1,  1'b1, '{11'd1920, 5'd24, 7'd0, 8'h00}},
      '{ACT_READ,   8'h00,        11'd1919, 1,  1'b1, '{11'd1920, 5'd24, 7'd0, 8'h7E}},
      '{ACT_CLEAR,  8'h00,        11'd0,    1,  1'b1, '{11'd0,    5'd0,  7'd0, 8'h00}}
   };

   text_console_cursor_scroll_top #(
      .ROW_COUNT(ROWS),
      .COL_COUNT(COLS)
   ) uut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_action     (req_action),
      .req_char_code  (req_char_code),
      .req_cell_index (req_cell_index),
      .rsp_valid      (rsp_valid),
      .rsp_cursor_pos (rsp_cursor_pos),
      .rsp_cur_row    (rsp_cur_row),
      .rsp_cur_col    (rsp_cur_col),
      .rsp_read_data  (rsp_read_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #80ms;
      $display("*** FAILED ***");
      $finish;
   end

   function automatic void blank_shadow();
      for (int i = 0; i < CELLS; i++) shadow_screen[i] = CH_SPACE;
      shadow_cursor = 0;
   endfunction

   function automatic console_report_type console_predict(input logic [ACTION_W-1:0] act,
                                                          input logic [CHAR_W-1:0]   ch,
                                                          input logic [INDEX_W-1:0]  idx);
      console_report_type rep;
      logic [CHAR_W-1:0] rd;
      rd = '0;
      if (shadow_cursor >= CELLS) shadow_cursor = 0;
      case (act)
         ACT_PUT: begin
            if (ch == CH_NEWLINE) begin
               shadow_cursor = (shadow_cursor / COLS + 1) * COLS;
            end else if (ch == CH_BACKSPACE) begin
               if (shadow_cursor > 0) shadow_cursor--;
               shadow_screen[shadow_cursor] = CH_SPACE;
            end else begin
               shadow_screen[shadow_cursor] = ch;
               shadow_cursor++;
            end
            // scroll up one row, last row filled with spaces
            while (shadow_cursor >= CELLS) begin
               for (int i = 0; i < CELLS - COLS; i++) shadow_screen[i] = shadow_screen[i + COLS];
               for (int i = CELLS - COLS; i < CELLS; i++) shadow_screen[i] = CH_SPACE;
               shadow_cursor -= COLS;
            end
         end
         ACT_READ: begin
            if (idx < CELLS) rd = shadow_screen[idx];
         end
         ACT_CLEAR: begin
            blank_shadow();
         end
         default: ;
      endcase
      rep.pos  = POS_W'(shadow_cursor);
      rep.row  = ROW_W'(shadow_cursor / COLS);
      rep.col  = COL_W'(shadow_cursor % COLS);
      rep.data = rd;
      return rep;
   endfunction

   task automatic issue_item(input logic [ACTION_W-1:0] act,
                             input logic [CHAR_W-1:0]   ch,
                             input logic [INDEX_W-1:0]  idx,
                             input bit                  typed,
                             input console_report_type  want,
                             input int                  gap,
                             input bit                  drain);
      console_report_type rep;
      req_action     <= act;
      req_char_code  <= ch;
      req_cell_index <= idx;
      start          <= 1'b1;
      @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
      rep = console_predict(act, ch, idx);
      cursor_report_q.push_back(typed ? want : rep);
      if (gap > 0 || drain) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
         while (drain && cursor_report_q.size() != 0) @(posedge clock);
      end
   endtask

   // response checking
   always @(posedge clock) begin
      console_report_type want;
      if (!reset && rsp_valid === 1'b1) begin
         if (cursor_report_q.size() == 0) begin
            $error("unexpected response transfer");
            fail_count++;
         end else begin
            want = cursor_report_q.pop_front();
            if (rsp_cursor_pos !== want.pos) begin
               $error("cursor_pos expected %0d actual %0d", want.pos, rsp_cursor_pos);
               fail_count++;
            end
            if (rsp_cur_row !== want.row) begin
               $error("cur_row expected %0d actual %0d", want.row, rsp_cur_row);
               fail_count++;
            end
            if (rsp_cur_col !== want.col) begin
               $error("cur_col expected %0d actual %0d", want.col, rsp_cur_col);
               fail_count++;
            end
            if (rsp_read_data !== want.data) begin
               $error("read_data expected 0x%0h actual 0x%0h", want.data, rsp_read_data);
               fail_count++;
            end
         end
      end
   end

   initial begin
      stim_row_type        row;
      logic [ACTION_W-1:0] act;
      logic [CHAR_W-1:0]   ch;
      logic [INDEX_W-1:0]  idx;
      int                  pick;
      int                  near;
      int                  gap;
      bit                  last;

      blank_shadow();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      for (int r = 0; r < DIR_ROWS; r++) begin
         row = directed_stim[r];
         for (int k = 0; k < row.reps; k++) begin
            last = (r == DIR_ROWS - 1) && (k == row.reps - 1);
            gap  = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
            issue_item(row.act, row.ch, row.idx, row.typed, row.want, gap, last);
         end
      end

      for (int n = 0; n < RAND_ITEMS; n++) begin
         ch   = CHAR_W'($urandom_range(0, 255));
         idx  = INDEX_W'($urandom_range(0, 2047));
         pick = $urandom_range(0, 99);
         if (pick < 1) begin
            act = ACT_CLEAR;
         end else if (pick < 6) begin
            act = ACT_UNUSED;
         end else if (pick < 26) begin
            act = ACT_READ;
            // half the time read back near what was just written
            if ($urandom_range(0, 1) == 0) begin
               near = shadow_cursor - int'($urandom_range(0, 159));
               if (near < 0) near = 0;
               idx = INDEX_W'(near);
            end
         end else begin
            act  = ACT_PUT;
            pick = $urandom_range(0, 99);
            if (pick < 22) ch = CH_NEWLINE;
            else if (pick < 32) ch = CH_BACKSPACE;
         end
         last = (n == RAND_ITEMS - 1);
         if (n >= RAND_ITEMS - CALM_ITEMS || $urandom_range(0, 3) != 0) gap = 0;
         else gap = $urandom_range(1, 3);
         issue_item(act, ch, idx, 1'b0, '0, gap, last || n == RAND_ITEMS / 2);
      end

      repeat (8) @(posedge clock);
      if (fail_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

/* text_console_cursor_scroll_top.f */
+incdir+rtl/core
rtl/core/tcc_pkg.sv
rtl/core/tcc_ctrl.sv
rtl/core/tcc_datapath.sv
rtl/core/text_console_cursor_scroll_top.sv
bench/text_console_cursor_scroll_top_tb.sv
